// ===== design/jkvs_pkg.sv =====
// ============================================================================
// jkvs_pkg
// Shared types, character codes, request kinds, result status codes and the
// control store of the key/value scanner sequencer.
// ============================================================================
`default_nettype none

package jkvs_pkg;

   // default sizes
   localparam int unsigned STORE_DEPTH_DEF = 4096;
   localparam int unsigned MAX_TARGET_DEF  = 16;

   // fixed field widths
   localparam int unsigned ADDR_W    = 12;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned NAME_W    = 12;
   localparam int unsigned OFFSET_W  = 13;
   localparam int unsigned TLEN_W    = 5;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 64;

   // characters
   localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
   localparam logic [BYTE_W-1:0] CH_END   = 8'h00;

   // request kinds
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_FIRST = 2'd1;
   localparam logic [1:0] KIND_NEXT  = 2'd2;

   // result status
   localparam logic [1:0] ST_FOUND    = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_NOCOLON  = 2'd2;
   localparam logic [1:0] ST_NOFIRST  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_LEN  = 2'd2;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ADDR_W-1:0] address;
      logic [BYTE_W-1:0] data;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [NAME_W-1:0]   name_offset;
      logic [OFFSET_W-1:0] value_offset;
      logic [OFFSET_W-1:0] value_length;
   } rsp_type;

   // control word fields
   localparam int unsigned UC_STEP_W = 5;

   localparam logic [1:0] RD_NONE = 2'd0;
   localparam logic [1:0] RD_CAND = 2'd1;
   localparam logic [1:0] RD_CUR  = 2'd2;

   localparam logic [3:0] ACT_NONE          = 4'd0;
   localparam logic [3:0] ACT_MISS          = 4'd1;
   localparam logic [3:0] ACT_IDX_INC       = 4'd2;
   localparam logic [3:0] ACT_MATCH         = 4'd3;
   localparam logic [3:0] ACT_CUR_INC       = 4'd4;
   localparam logic [3:0] ACT_TERM_COMMA    = 4'd5;
   localparam logic [3:0] ACT_TERM_QUOTE    = 4'd6;
   localparam logic [3:0] ACT_VAL_START     = 4'd7;
   localparam logic [3:0] ACT_VAL_INC       = 4'd8;
   localparam logic [3:0] ACT_DONE_FOUND    = 4'd9;
   localparam logic [3:0] ACT_DONE_NOTFOUND = 4'd10;
   localparam logic [3:0] ACT_DONE_NOCOLON  = 4'd11;
   localparam logic [3:0] ACT_DONE_NOFIRST  = 4'd12;

   localparam logic [3:0] COND_NEVER     = 4'd0;
   localparam logic [3:0] COND_ALWAYS    = 4'd1;
   localparam logic [3:0] COND_HEAD_END  = 4'd2;
   localparam logic [3:0] COND_IDX_DONE  = 4'd3;
   localparam logic [3:0] COND_MISMATCH  = 4'd4;
   localparam logic [3:0] COND_BYTE_TEXT = 4'd5;
   localparam logic [3:0] COND_BYTE_END  = 4'd6;
   localparam logic [3:0] COND_COLON     = 4'd7;
   localparam logic [3:0] COND_NOT_QUOTE = 4'd8;
   localparam logic [3:0] COND_VAL_END   = 4'd9;

   // program steps
   localparam logic [UC_STEP_W-1:0] UC_IDLE      = 5'd0;
   localparam logic [UC_STEP_W-1:0] UC_SRCH_RD   = 5'd1;
   localparam logic [UC_STEP_W-1:0] UC_SRCH_HEAD = 5'd2;
   localparam logic [UC_STEP_W-1:0] UC_SRCH_LEN  = 5'd3;
   localparam logic [UC_STEP_W-1:0] UC_SRCH_CMP  = 5'd4;
   localparam logic [UC_STEP_W-1:0] UC_SRCH_ADV  = 5'd5;
   localparam logic [UC_STEP_W-1:0] UC_MATCH     = 5'd6;
   localparam logic [UC_STEP_W-1:0] UC_COL_RD    = 5'd7;
   localparam logic [UC_STEP_W-1:0] UC_COL_END   = 5'd8;
   localparam logic [UC_STEP_W-1:0] UC_COL_CHK   = 5'd9;
   localparam logic [UC_STEP_W-1:0] UC_COL_ADV   = 5'd10;
   localparam logic [UC_STEP_W-1:0] UC_COL_SKIP  = 5'd11;
   localparam logic [UC_STEP_W-1:0] UC_Q_RD      = 5'd12;
   localparam logic [UC_STEP_W-1:0] UC_Q_CHK     = 5'd13;
   localparam logic [UC_STEP_W-1:0] UC_QUOTED    = 5'd14;
   localparam logic [UC_STEP_W-1:0] UC_VAL_START = 5'd15;
   localparam logic [UC_STEP_W-1:0] UC_V_RD      = 5'd16;
   localparam logic [UC_STEP_W-1:0] UC_V_CHK     = 5'd17;
   localparam logic [UC_STEP_W-1:0] UC_V_ADV     = 5'd18;
   localparam logic [UC_STEP_W-1:0] UC_FOUND     = 5'd19;
   localparam logic [UC_STEP_W-1:0] UC_NOTFOUND  = 5'd20;
   localparam logic [UC_STEP_W-1:0] UC_NOCOLON   = 5'd21;
   localparam logic [UC_STEP_W-1:0] UC_MISS      = 5'd22;
   localparam logic [UC_STEP_W-1:0] UC_NOFIRST   = 5'd23;

   typedef struct packed {
      logic [1:0]           rd;
      logic [3:0]           act;
      logic [3:0]           cond;
      logic [UC_STEP_W-1:0] target;
   } uc_type;

   function automatic uc_type uc_word(input logic [1:0] rd, input logic [3:0] act,
                                      input logic [3:0] cond,
                                      input logic [UC_STEP_W-1:0] target);
      uc_type w;
      w.rd     = rd;
      w.act    = act;
      w.cond   = cond;
      w.target = target;
      return w;
   endfunction

   // control store: taken jump goes to target, else to the next step
   function automatic uc_type uc_rom(input logic [UC_STEP_W-1:0] step);
      uc_type w;
      unique case (step)
         UC_SRCH_RD:   w = uc_word(RD_CAND, ACT_NONE, COND_NEVER, UC_IDLE);
         UC_SRCH_HEAD: w = uc_word(RD_NONE, ACT_NONE, COND_HEAD_END, UC_NOTFOUND);
         UC_SRCH_LEN:  w = uc_word(RD_NONE, ACT_NONE, COND_IDX_DONE, UC_MATCH);
         UC_SRCH_CMP:  w = uc_word(RD_NONE, ACT_NONE, COND_MISMATCH, UC_MISS);
         UC_SRCH_ADV:  w = uc_word(RD_NONE, ACT_IDX_INC, COND_BYTE_TEXT, UC_SRCH_RD);
         UC_MATCH:     w = uc_word(RD_NONE, ACT_MATCH, COND_NEVER, UC_IDLE);
         UC_COL_RD:    w = uc_word(RD_CUR, ACT_NONE, COND_NEVER, UC_IDLE);
         UC_COL_END:   w = uc_word(RD_NONE, ACT_NONE, COND_BYTE_END, UC_NOCOLON);
         UC_COL_CHK:   w = uc_word(RD_NONE, ACT_NONE, COND_COLON, UC_COL_SKIP);
         UC_COL_ADV:   w = uc_word(RD_NONE, ACT_CUR_INC, COND_ALWAYS, UC_COL_RD);
         UC_COL_SKIP:  w = uc_word(RD_NONE, ACT_CUR_INC, COND_NEVER, UC_IDLE);
         UC_Q_RD:      w = uc_word(RD_CUR, ACT_NONE, COND_NEVER, UC_IDLE);
         UC_Q_CHK:     w = uc_word(RD_NONE, ACT_TERM_COMMA, COND_NOT_QUOTE, UC_VAL_START);
         UC_QUOTED:    w = uc_word(RD_NONE, ACT_TERM_QUOTE, COND_NEVER, UC_IDLE);
         UC_VAL_START: w = uc_word(RD_NONE, ACT_VAL_START, COND_NEVER, UC_IDLE);
         UC_V_RD:      w = uc_word(RD_CUR, ACT_NONE, COND_NEVER, UC_IDLE);
         UC_V_CHK:     w = uc_word(RD_NONE, ACT_NONE, COND_VAL_END, UC_FOUND);
         UC_V_ADV:     w = uc_word(RD_NONE, ACT_VAL_INC, COND_ALWAYS, UC_V_RD);
         UC_FOUND:     w = uc_word(RD_NONE, ACT_DONE_FOUND, COND_ALWAYS, UC_IDLE);
         UC_NOTFOUND:  w = uc_word(RD_NONE, ACT_DONE_NOTFOUND, COND_ALWAYS, UC_IDLE);
         UC_NOCOLON:   w = uc_word(RD_NONE, ACT_DONE_NOCOLON, COND_ALWAYS, UC_IDLE);
         UC_MISS:      w = uc_word(RD_NONE, ACT_MISS, COND_ALWAYS, UC_SRCH_RD);
         UC_NOFIRST:   w = uc_word(RD_NONE, ACT_DONE_NOFIRST, COND_ALWAYS, UC_IDLE);
         default:      w = uc_word(RD_NONE, ACT_NONE, COND_NEVER, UC_IDLE);
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== design/json_key_value_scanner_core.sv =====
// ============================================================================
// json_key_value_scanner_core
// Byte store with a microcoded search for a target key and its value.
// ============================================================================
// Requests arrive on req_* (valid/ready). A load request writes one byte of
// text into the store and yields no result. A first query searches for the
// target string from offset 0, a next query resumes one byte after the
// previous match start; each query returns one result on rsp_* (status,
// name offset, value offset, value length). The target string and its
// length are written over csr_*; the user must do so only while the block
// is idle, as the block itself does not enforce it. A query runs a control
// program one step per cycle while its result is not stalled, with at most
// one store read per step. Each target byte compared at a candidate
// position takes the steps read, head check, length check, compare and
// advance; each byte walked to the colon takes read, end check, colon check
// and advance; each value byte takes read, check and advance. req_ready is
// high whenever the sequencer is idle, also while a result waits; a stalled
// result holds the sequencer at its result step. Reset clears the sequencer,
// the scan flag, position, candidate and index, the target registers and the
// result valid; the text store is undefined until loaded.
// ============================================================================
`default_nettype none

module json_key_value_scanner_core #(
   parameter int unsigned STORE_DEPTH = jkvs_pkg::STORE_DEPTH_DEF,
   parameter int unsigned MAX_TARGET  = jkvs_pkg::MAX_TARGET_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire jkvs_pkg::req_type                    req_item,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output jkvs_pkg::rsp_type                         rsp_item,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [jkvs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [jkvs_pkg::CSR_DAT_W-1:0]       csr_data
);
   import jkvs_pkg::*;

   localparam int unsigned AW = $clog2(STORE_DEPTH);
   localparam int unsigned PW = AW + 1;
   localparam int unsigned XW = (AW > ADDR_W) ? AW : ADDR_W;

   logic [BYTE_W-1:0] mem [STORE_DEPTH];

   logic [UC_STEP_W-1:0] step_ff, step_in;
   logic                 active_ff, active_in;
   logic [PW-1:0]        pos_ff, pos_in;
   logic [PW-1:0]        cand_ff, cand_in;
   logic [TLEN_W-1:0]    idx_ff, idx_in;
   logic [PW-1:0]        cur_ff, cur_in;
   logic [PW-1:0]        voff_ff, voff_in;
   logic [PW-1:0]        vlen_ff, vlen_in;
   logic                 quoted_ff, quoted_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_item_ff, rsp_item_in;
   logic [2*CSR_DAT_W-1:0] target_ff;
   logic [TLEN_W-1:0]    tlen_ff;
   logic [BYTE_W-1:0]    mem_q_ff;
   logic                 rd_oob_ff;

   uc_type               uc;
   logic                 req_acc;
   logic                 load_wr;
   logic [XW:0]          wr_ext;
   logic [AW-1:0]        wr_idx;
   logic [PW-1:0]        rd_addr;
   logic                 rd_oob;
   logic                 rd_en;
   logic [AW-1:0]        rd_idx;
   logic [BYTE_W-1:0]    rd_byte;
   logic [BYTE_W-1:0]    tgt_byte;
   logic [BYTE_W-1:0]    term_byte;
   logic [TLEN_W-1:0]    tlen_eff;
   logic                 emit;
   logic                 stall;
   logic                 cond_true;

   assign uc        = uc_rom(step_ff);
   assign req_ready = (step_ff == UC_IDLE);
   assign req_acc   = req_valid & req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign wr_ext  = (XW+1)'(req_item.address);
   assign wr_idx  = wr_ext[AW-1:0];
   assign load_wr = req_acc && (req_item.kind == KIND_LOAD)
                    && (wr_ext < (XW+1)'(STORE_DEPTH));

   assign rd_addr   = (uc.rd == RD_CAND) ? (cand_ff + PW'(idx_ff)) : cur_ff;
   assign rd_oob    = (rd_addr >= PW'(STORE_DEPTH));
   assign rd_idx    = rd_oob ? '0 : rd_addr[AW-1:0];
   assign rd_byte   = rd_oob_ff ? CH_END : mem_q_ff;
   assign tgt_byte  = target_ff[{idx_ff[3:0], 3'b000} +: BYTE_W];
   assign term_byte = quoted_ff ? CH_QUOTE : CH_COMMA;
   assign tlen_eff  = (tlen_ff > TLEN_W'(MAX_TARGET)) ? TLEN_W'(MAX_TARGET) : tlen_ff;

   assign emit  = (uc.act == ACT_DONE_FOUND) || (uc.act == ACT_DONE_NOTFOUND)
                  || (uc.act == ACT_DONE_NOCOLON) || (uc.act == ACT_DONE_NOFIRST);
   assign stall = emit & rsp_valid_ff & ~rsp_ready;
   assign rd_en = (uc.rd != RD_NONE) & ~stall;

   always_comb begin
      unique case (uc.cond)
         COND_NEVER:     cond_true = 1'b0;
         COND_ALWAYS:    cond_true = 1'b1;
         COND_HEAD_END:  cond_true = (idx_ff == '0) && (rd_byte == CH_END);
         COND_IDX_DONE:  cond_true = (idx_ff >= tlen_eff);
         COND_MISMATCH:  cond_true = (rd_byte != tgt_byte);
         COND_BYTE_TEXT: cond_true = (rd_byte != CH_END);
         COND_BYTE_END:  cond_true = (rd_byte == CH_END);
         COND_COLON:     cond_true = (rd_byte == CH_COLON);
         COND_NOT_QUOTE: cond_true = (rd_byte != CH_QUOTE);
         COND_VAL_END:   cond_true = (rd_byte == CH_END) || (rd_byte == term_byte);
         default:        cond_true = 1'b0;
      endcase
   end

   always_comb begin
      step_in      = step_ff;
      active_in    = active_ff;
      pos_in       = pos_ff;
      cand_in      = cand_ff;
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      voff_in      = voff_ff;
      vlen_in      = vlen_ff;
      quoted_in    = quoted_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_item_in  = rsp_item_ff;
      if (step_ff == UC_IDLE) begin
         if (req_acc) begin
            unique case (req_item.kind)
               KIND_FIRST: begin
                  pos_in    = '0;
                  active_in = 1'b1;
                  cand_in   = '0;
                  idx_in    = '0;
                  step_in   = UC_SRCH_RD;
               end
               KIND_NEXT: begin
                  if (active_ff) begin
                     cand_in = pos_ff;
                     idx_in  = '0;
                     step_in = UC_SRCH_RD;
                  end else begin
                     step_in = UC_NOFIRST;
                  end
               end
               default: begin
               end
            endcase
         end
      end else if (!stall) begin
         unique case (uc.act)
            ACT_NONE: begin
            end
            ACT_MISS: begin
               cand_in = cand_ff + PW'(1);
               idx_in  = '0;
            end
            ACT_IDX_INC: idx_in = idx_ff + TLEN_W'(1);
            ACT_MATCH: begin
               pos_in = cand_ff + PW'(1);
               cur_in = cand_ff;
            end
            ACT_CUR_INC:    cur_in = cur_ff + PW'(1);
            ACT_TERM_COMMA: quoted_in = 1'b0;
            ACT_TERM_QUOTE: begin
               quoted_in = 1'b1;
               cur_in    = cur_ff + PW'(1);
            end
            ACT_VAL_START: begin
               voff_in = cur_ff;
               vlen_in = '0;
            end
            ACT_VAL_INC: begin
               cur_in  = cur_ff + PW'(1);
               vlen_in = vlen_ff + PW'(1);
            end
            ACT_DONE_FOUND: begin
               rsp_valid_in             = 1'b1;
               rsp_item_in.status       = ST_FOUND;
               rsp_item_in.name_offset  = NAME_W'(cand_ff);
               rsp_item_in.value_offset = OFFSET_W'(voff_ff);
               rsp_item_in.value_length = OFFSET_W'(vlen_ff);
            end
            ACT_DONE_NOTFOUND: begin
               active_in                = 1'b0;
               rsp_valid_in             = 1'b1;
               rsp_item_in.status       = ST_NOTFOUND;
               rsp_item_in.name_offset  = '0;
               rsp_item_in.value_offset = '0;
               rsp_item_in.value_length = '0;
            end
            ACT_DONE_NOCOLON: begin
               active_in                = 1'b0;
               rsp_valid_in             = 1'b1;
               rsp_item_in.status       = ST_NOCOLON;
               rsp_item_in.name_offset  = NAME_W'(cand_ff);
               rsp_item_in.value_offset = '0;
               rsp_item_in.value_length = '0;
            end
            ACT_DONE_NOFIRST: begin
               rsp_valid_in             = 1'b1;
               rsp_item_in.status       = ST_NOFIRST;
               rsp_item_in.name_offset  = '0;
               rsp_item_in.value_offset = '0;
               rsp_item_in.value_length = '0;
            end
            default: begin
            end
         endcase
         step_in = cond_true ? uc.target : (step_ff + UC_STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (load_wr) begin
         mem[wr_idx] <= req_item.data;
      end
      if (rd_en) begin
         mem_q_ff  <= mem[rd_idx];
         rd_oob_ff <= rd_oob;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= UC_IDLE;
         active_ff    <= 1'b0;
         pos_ff       <= '0;
         cand_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         target_ff    <= '0;
         tlen_ff      <= '0;
      end else begin
         step_ff      <= step_in;
         active_ff    <= active_in;
         pos_ff       <= pos_in;
         cand_ff      <= cand_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_TARGET_LOW:  target_ff[CSR_DAT_W-1:0] <= csr_data;
               CSR_TARGET_HIGH: target_ff[2*CSR_DAT_W-1:CSR_DAT_W] <= csr_data;
               CSR_TARGET_LEN:  tlen_ff <= csr_data[TLEN_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      voff_ff     <= voff_in;
      vlen_ff     <= vlen_in;
      quoted_ff   <= quoted_in;
      rsp_item_ff <= rsp_item_in;
   end

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (step_ff != UC_IDLE) |-> (idx_ff <= TLEN_W'(MAX_TARGET)))
      else $error("target index beyond maximum target length");

   a_cand_bound: assert property (@(posedge clock) disable iff (reset)
      (step_ff != UC_IDLE) |-> (cand_ff <= PW'(STORE_DEPTH)))
      else $error("candidate position beyond store end");

   a_clear_scan: assert property (@(posedge clock) disable iff (reset)
      ((uc.act == ACT_DONE_NOTFOUND || uc.act == ACT_DONE_NOCOLON) && !stall)
      |=> !active_ff)
      else $error("scan still active after failed query");

   a_nofirst: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && rsp_item_ff.status == ST_NOFIRST) |-> !active_ff)
      else $error("next-without-first reported while scan active");

   a_found_order: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && rsp_item_ff.status == ST_FOUND) |-> (voff_ff > cand_ff))
      else $error("value offset not past name offset");

endmodule

`default_nettype wire

// ===== bench/json_key_value_scanner_core_test.sv =====
// ============================================================================
// json_key_value_scanner_core_test
// Self-checking bench for the key/value scanner. Text is loaded into the
// store and the target is set over the register port. Every query result is
// compared with a cycle-free predictor kept inside the bench. Both channels
// idle at random, one long result stall backs the block up, and one pass
// fills the whole store to reach its end.
// ============================================================================
`timescale 1ns / 1ps

module json_key_value_scanner_core_test;
   import jkvs_pkg::*;

   localparam int unsigned     STORE_SIZE      = STORE_DEPTH_DEF;
   localparam int unsigned     KEY_MAX         = MAX_TARGET_DEF;
   localparam logic [1:0]      KIND_UNUSED     = 2'd3;
   localparam int unsigned     SETTLE_CYCLES   = 8;
   localparam longint unsigned CYCLE_LIMIT     = 3000000;
   localparam int unsigned     RANDOM_REQUESTS = 140;
   localparam int unsigned     STALL_CYCLES    = 400;
   localparam int unsigned     REPORT_MAX      = 10;
   localparam logic [7:0]      FILL_CHAR       = 8'h78;
   localparam logic [7:0]      KEY_CHAR        = 8'h61;
   localparam logic [7:0]      DIGIT_CHAR      = 8'h30;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_item  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_item;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data  = '0;

   // predictor state
   logic [7:0]  text_store [STORE_SIZE];
   bit          text_written [STORE_SIZE];
   int unsigned scan_point = 0;
   bit          scan_live  = 1'b0;
   logic [63:0] key_low    = '0;
   logic [63:0] key_high   = '0;
   logic [4:0]  key_len    = '0;
   rsp_type     pending_results [$];

   int unsigned     send_idle_pct   = 34;
   int unsigned     recv_idle_pct   = 77;
   int unsigned     stall_left      = 0;
   int unsigned     mismatch_count  = 0;
   int unsigned     results_checked = 0;
   int unsigned     queries_sent    = 0;
   int unsigned     loads_sent      = 0;
   longint unsigned cycle_count     = 0;

   json_key_value_scanner_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [7:0] text_at(int unsigned p);
      if (p < STORE_SIZE) return text_store[p];
      return CH_END;
   endfunction

   function automatic bit text_live(int unsigned p);
      if (p >= STORE_SIZE) return 1'b0;
      return text_store[p] != CH_END;
   endfunction

   function automatic bit key_at(int unsigned p);
      logic [127:0] key;
      int unsigned  n;
      key = {key_high, key_low};
      n = (key_len > KEY_MAX) ? KEY_MAX : key_len;
      for (int unsigned i = 0; i < n; i++) begin
         if (text_at(p + i) != key[8*i +: 8]) return 1'b0;
         if (text_at(p + i) == CH_END) return 1'b1;
      end
      return 1'b1;
   endfunction

   // apply one request to the predictor; return 1 when it yields a result
   function automatic bit scan_request(input req_type r, output rsp_type res);
      int unsigned p;
      int unsigned c;
      int unsigned vlen;
      logic [7:0]  stop_char;
      res = '0;
      if (r.kind == KIND_LOAD) begin
         text_store[r.address] = r.data;
         text_written[r.address] = 1'b1;
         return 1'b0;
      end
      if (r.kind == KIND_UNUSED) return 1'b0;
      if (r.kind == KIND_FIRST) begin
         scan_point = 0;
         scan_live = 1'b1;
      end else if (!scan_live) begin
         res.status = ST_NOFIRST;
         return 1'b1;
      end
      p = scan_point;
      while (text_live(p) && !key_at(p)) p++;
      if (!text_live(p)) begin
         scan_live = 1'b0;
         res.status = ST_NOTFOUND;
         return 1'b1;
      end
      res.name_offset = p[NAME_W-1:0];
      scan_point = (p + 1) & 32'h1FFF;
      c = p;
      while (text_live(c) && text_store[c] != CH_COLON) c++;
      if (!text_live(c)) begin
         scan_live = 1'b0;
         res.status = ST_NOCOLON;
         return 1'b1;
      end
      stop_char = CH_COMMA;
      c++;
      if (text_at(c) == CH_QUOTE) begin
         stop_char = CH_QUOTE;
         c++;
      end
      res.value_offset = c[OFFSET_W-1:0];
      vlen = 0;
      while (text_live(c) && text_store[c] != stop_char) begin
         c++;
         vlen++;
      end
      res.value_length = vlen[OFFSET_W-1:0];
      res.status = ST_FOUND;
      return 1'b1;
   endfunction

   // force a stray byte to zero when it would run the text into unloaded entries
   function automatic logic [7:0] keep_terminated(int unsigned addr, logic [7:0] val);
      for (int unsigned i = 0; i < STORE_SIZE; i++) begin
         if (i == addr) begin
            if (val == CH_END) return val;
         end else if (!text_written[i]) begin
            return (i > addr) ? CH_END : val;
         end else if (text_store[i] == CH_END) begin
            return val;
         end
      end
      return val;
   endfunction

   task automatic send_request(input logic [1:0] kind, input logic [ADDR_W-1:0] address,
                               input logic [BYTE_W-1:0] data);
      req_type     r;
      rsp_type     res;
      int unsigned gap;
      r.kind = kind;
      r.address = address;
      r.data = data;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_item <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (scan_request(r, res)) pending_results.push_back(res);
      if (kind == KIND_LOAD) loads_sent++;
      else if (kind != KIND_UNUSED) queries_sent++;
   endtask

   task automatic send_query(input logic [1:0] kind);
      send_request(kind, ADDR_W'($urandom_range(0, 4095)), BYTE_W'($urandom_range(0, 255)));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_register(input logic [CSR_IDX_W-1:0] index,
                               input logic [CSR_DAT_W-1:0] value);
      csr_index <= index;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_TARGET_LOW:  key_low = value;
         CSR_TARGET_HIGH: key_high = value;
         default:         key_len = value[TLEN_W-1:0];
      endcase
   endtask

   task automatic write_target(input logic [63:0] low, input logic [63:0] high,
                               input logic [4:0] len);
      set_register(CSR_TARGET_LOW, low);
      set_register(CSR_TARGET_HIGH, high);
      set_register(CSR_TARGET_LEN, {59'd0, len});
      csr_valid <= 1'b0;
   endtask

   task automatic test_next_before_first();
      send_query(KIND_NEXT);
      send_query(KIND_UNUSED);
   endtask

   task automatic test_empty_text();
      send_request(KIND_LOAD, '0, CH_END);
      send_query(KIND_FIRST);
      send_query(KIND_NEXT);
   endtask

   // quoted value, unquoted value, key with no colon, then next after the scan ended
   task automatic test_record_walk();
      string text;
      text = "ab:\"q\"ab:7,ab";
      settle();
      write_target(64'h6261, 64'h0, 5'd2);
      for (int i = 0; i < text.len(); i++) send_request(KIND_LOAD, ADDR_W'(i), text[i]);
      send_request(KIND_LOAD, ADDR_W'(text.len()), CH_END);
      send_query(KIND_FIRST);
      send_query(KIND_NEXT);
      send_query(KIND_NEXT);
      send_query(KIND_NEXT);
   endtask

   task automatic test_target_extremes();
      settle();
      write_target(64'h6261, 64'h0, 5'd0);
      send_query(KIND_FIRST);
      settle();
      write_target({64{1'b1}}, {64{1'b1}}, 5'd31);
      send_query(KIND_FIRST);
      settle();
      // zero after the key matches the text end
      write_target(64'h6261, 64'h0, 5'd16);
      send_query(KIND_FIRST);
   endtask

   task automatic test_random_records();
      logic [7:0]   text_buf [96];
      logic [127:0] key;
      int unsigned  len;
      int unsigned  start;
      int unsigned  n;
      int unsigned  pick;
      int unsigned  addr;
      int unsigned  base;
      int unsigned  done;
      bit           quoted;
      bit           started;
      base = loads_sent + queries_sent;
      done = 0;
      while (done < RANDOM_REQUESTS) begin
         if (done < RANDOM_REQUESTS / 3) begin
            send_idle_pct = 34;
            recv_idle_pct = 77;
         end else if (done < 2 * RANDOM_REQUESTS / 3) begin
            send_idle_pct = 77;
            recv_idle_pct = 34;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         foreach (text_buf[i]) text_buf[i] = CH_END;
         len = 0;
         repeat ($urandom_range(1, 3)) begin
            quoted = 1'($urandom_range(1));
            if (quoted) begin
               text_buf[len] = CH_QUOTE;
               len++;
            end
            repeat ($urandom_range(1, 3)) begin
               text_buf[len] = KEY_CHAR + 8'($urandom_range(0, 2));
               len++;
            end
            if (quoted && $urandom_range(3) != 0) begin
               text_buf[len] = CH_QUOTE;
               len++;
            end
            if ($urandom_range(9) != 0) begin
               text_buf[len] = CH_COLON;
               len++;
            end
            quoted = 1'($urandom_range(1));
            if (quoted) begin
               text_buf[len] = CH_QUOTE;
               len++;
            end
            repeat ($urandom_range(0, 4)) begin
               if ($urandom_range(3) == 0) text_buf[len] = 8'($urandom_range(1, 255));
               else text_buf[len] = DIGIT_CHAR + 8'($urandom_range(0, 9));
               len++;
            end
            if ($urandom_range(3) != 0) begin
               text_buf[len] = quoted ? CH_QUOTE : CH_COMMA;
               len++;
            end
         end
         if ($urandom_range(4) == 0) begin
            key = {$urandom, $urandom, $urandom, $urandom};
         end else begin
            start = $urandom_range(0, len);
            for (int i = 0; i < 16; i++) key[8*i +: 8] = text_buf[start + i];
         end
         pick = $urandom_range(19);
         if (pick == 0) n = $urandom_range(17, 31);
         else if (pick < 3) n = $urandom_range(6, 16);
         else n = $urandom_range(0, 5);
         settle();
         write_target(key[63:0], key[127:64], n[4:0]);
         for (int unsigned i = 0; i <= len; i++)
            send_request(KIND_LOAD, ADDR_W'(i), text_buf[i]);
         started = 1'b0;
         repeat ($urandom_range(5, 9)) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
               if (!started || $urandom_range(5) == 0) send_query(KIND_FIRST);
               else send_query(KIND_NEXT);
               started = 1'b1;
            end else if (pick < 92) begin
               addr = (pick < 82) ? $urandom_range(0, 4095) : $urandom_range(0, len);
               send_request(KIND_LOAD, ADDR_W'(addr),
                            keep_terminated(addr, BYTE_W'($urandom_range(0, 255))));
            end else begin
               send_query(KIND_UNUSED);
            end
         end
         done = loads_sent + queries_sent - base;
      end
   endtask

   // hold results back while requests keep coming so the block backs up
   task automatic test_result_stall();
      int unsigned addr;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_left = STALL_CYCLES;
      send_query(KIND_FIRST);
      send_query(KIND_NEXT);
      addr = $urandom_range(0, 4095);
      send_request(KIND_LOAD, ADDR_W'(addr),
                   keep_terminated(addr, BYTE_W'($urandom_range(0, 255))));
      send_query(KIND_NEXT);
      send_query(KIND_FIRST);
      send_query(KIND_NEXT);
   endtask

   // text fills the whole store, so scans stop at its end
   task automatic test_store_end();
      logic [7:0] fill;
      settle();
      write_target(64'h796B, 64'h0, 5'd2);
      for (int unsigned i = 0; i < STORE_SIZE; i++) begin
         case (i)
            STORE_SIZE - 6: fill = 8'h6B;
            STORE_SIZE - 5: fill = 8'h79;
            STORE_SIZE - 4: fill = CH_COLON;
            STORE_SIZE - 3: fill = CH_QUOTE;
            STORE_SIZE - 2: fill = 8'h61;
            STORE_SIZE - 1: fill = 8'h6B;
            default:        fill = FILL_CHAR;
         endcase
         send_request(KIND_LOAD, ADDR_W'(i), fill);
      end
      send_query(KIND_FIRST);
      send_query(KIND_NEXT);
      settle();
      // colon in the last entry leaves the value offset at the store size
      write_target(64'h71, 64'h0, 5'd1);
      send_request(KIND_LOAD, ADDR_W'(STORE_SIZE - 2), 8'h71);
      send_request(KIND_LOAD, ADDR_W'(STORE_SIZE - 1), CH_COLON);
      send_query(KIND_FIRST);
      send_query(KIND_NEXT);
   endtask

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (rsp_valid && rsp_ready) begin
         results_checked++;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("%0t: unexpected result status %0d name %0d value %0d len %0d",
                        $realtime, rsp_item.status, rsp_item.name_offset,
                        rsp_item.value_offset, rsp_item.value_length);
         end else begin
            want = pending_results.pop_front();
            if (rsp_item.status !== want.status
                || rsp_item.name_offset !== want.name_offset
                || rsp_item.value_offset !== want.value_offset
                || rsp_item.value_length !== want.value_length) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("%0t: result mismatch, expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                           $realtime, want.status, want.name_offset, want.value_offset,
                           want.value_length, rsp_item.status, rsp_item.name_offset,
                           rsp_item.value_offset, rsp_item.value_length);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("json_key_value_scanner_core test failed");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_next_before_first();
      test_empty_text();
      test_record_walk();
      test_target_extremes();
      test_random_records();
      test_result_stall();
      test_store_end();
      settle();
      $display("ran %0d loads and %0d queries, checked %0d results, %0d mismatches",
               loads_sent, queries_sent, results_checked, mismatch_count);
      $display("covered directed records, random records in three idle modes,");
      $display("a %0d-cycle result stall and a scan to the end of a full store", STALL_CYCLES);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("json_key_value_scanner_core test passed");
      else
         $display("json_key_value_scanner_core test failed");
      $finish;
   end

endmodule

// ===== files.f =====
design/jkvs_pkg.sv
design/json_key_value_scanner_core.sv
bench/json_key_value_scanner_core_test.sv
